/* design/b64e_pkg.sv */
// shared types, constants and the character table for the base64 encoder
`timescale 1ns / 1ps
package b64e_pkg;

  // ascii code of the '=' pad character
  localparam logic [6:0] PAD_CHAR = 7'd61;

  // position of a byte within its three-byte group
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_t;

  // one classified request: up to four characters and the index of the last one
  typedef struct packed {
    logic [3:0][6:0] chars;
    logic [1:0]      last_idx;
  } entry_t;

  // map a sextet onto the standard alphabet
  function automatic logic [6:0] b64_char(input logic [5:0] sextet);
    logic [6:0] v;
    logic [6:0] c;
    v = {1'b0, sextet};
    if (sextet < 6'd26) begin
      c = 7'd65 + v;
    end else if (sextet < 6'd52) begin
      c = 7'd71 + v;
    end else if (sextet < 6'd62) begin
      c = v - 7'd4;
    end else if (sextet == 6'd62) begin
      c = 7'd43;
    end else begin
      c = 7'd47;
    end
    return c;
  endfunction

endpackage

/* design/base64_encoder.sv */
// top level of the streaming base64 encoder
`timescale 1ns / 1ps
// Streaming Base64 encoder, standard alphabet with '=' padding. One message
// byte enters per request (tlast marks the final byte) and one ASCII character
// leaves per request, tlast set on the last character each byte causes. A
// byte is taken in the cycle it arrives whenever the request queue has room,
// so input can run back to back for short bursts; the sustained rate is set
// by the output stage, which sends one character per cycle while out_tready
// is high: a byte yields one character in the first and second place of a
// group and two in the third, and a last byte yields two to four characters
// for flush and padding. The first character of a byte passes through the
// request queue and the output register before it is valid on the output.
module base64_encoder #(
  parameter int FIFO_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // is_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [6:0] char_code, [7] zero
  output logic       out_tlast   // end_of_run
);
  import b64e_pkg::*;

  entry_t     front_entry;
  entry_t     head;
  logic       push;
  logic       pop;
  logic       full;
  logic       empty;
  logic [6:0] char_code;

  assign in_tready = !full;
  assign push      = in_tvalid && !full;
  assign out_tdata = {1'b0, char_code};

  // byte classification and group state
  b64e_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .data_byte (in_tdata),
    .is_last   (in_tlast),
    .entry     (front_entry)
  );

  // request queue
  b64e_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (front_entry),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  // character serializer and output register
  b64e_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .char_code  (char_code),
    .end_of_run (out_tlast)
  );

endmodule

/* design/b64e_front.sv */
// front end: group tracking and translation of each byte into its characters
`timescale 1ns / 1ps
module b64e_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,       // byte request taken this cycle
  input  logic [7:0]        data_byte,
  input  logic              is_last,
  output b64e_pkg::entry_t  entry
);
  import b64e_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [3:0] leftover_r, leftover_nxt;

  // next group position and leftover bits
  always_comb begin
    phase_nxt    = phase_r;
    leftover_nxt = leftover_r;
    if (push) begin
      case (phase_r)
        PH_SECOND: begin
          phase_nxt    = PH_THIRD;
          leftover_nxt = data_byte[3:0];
        end
        PH_THIRD: begin
          phase_nxt    = PH_FIRST;
          leftover_nxt = 4'd0;
        end
        default: begin
          phase_nxt    = PH_SECOND;
          leftover_nxt = {2'b00, data_byte[1:0]};
        end
      endcase
      if (is_last) begin
        phase_nxt    = PH_FIRST;
        leftover_nxt = 4'd0;
      end
    end
  end

  // characters produced by this byte
  always_comb begin
    entry.chars    = {4{PAD_CHAR}};
    entry.last_idx = 2'd0;
    case (phase_r)
      PH_SECOND: begin
        entry.chars[0] = b64_char({leftover_r[1:0], data_byte[7:4]});
        if (is_last) begin
          entry.chars[1] = b64_char({data_byte[3:0], 2'b00});
          entry.last_idx = 2'd2;
        end
      end
      PH_THIRD: begin
        entry.chars[0] = b64_char({leftover_r, data_byte[7:6]});
        entry.chars[1] = b64_char(data_byte[5:0]);
        entry.last_idx = 2'd1;
      end
      default: begin
        entry.chars[0] = b64_char(data_byte[7:2]);
        if (is_last) begin
          entry.chars[1] = b64_char({data_byte[1:0], 4'b0000});
          entry.last_idx = 2'd3;
        end
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_FIRST;
      leftover_r <= 4'd0;
    end else begin
      phase_r    <= phase_nxt;
      leftover_r <= leftover_nxt;
    end
  end

`ifndef SYNTHESIS
  // a group start never carries leftover bits
  a_first_clean: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_FIRST |-> leftover_r == 4'd0)
    else $error("leftover bits at group start");
  // a last byte always closes the group
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    push && is_last |=> phase_r == PH_FIRST)
    else $error("group not closed after last byte");
`endif

endmodule

/* design/b64e_fifo.sv */
// short queue of classified requests between front and back end
`timescale 1ns / 1ps
module b64e_fifo #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  b64e_pkg::entry_t  push_data,
  output logic              full,
  input  logic              pop,
  output b64e_pkg::entry_t  head,
  output logic              empty
);
  import b64e_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  entry_t          mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign full  = (count_r == FULL_CNT);
  assign empty = (count_r == '0);
  assign head  = mem[rd_ptr_r];

  // pointer and fill count updates
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  // no overflow and no underflow
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("pop from empty queue");
`endif

endmodule

/* design/b64e_back.sv */
// back end: emits the characters of each request one per cycle while the output is ready
`timescale 1ns / 1ps
module b64e_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              empty,
  input  b64e_pkg::entry_t  head,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [6:0]        char_code,
  output logic              end_of_run
);
  import b64e_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [6:0] char_r;
  logic       last_r;
  logic       load;
  logic       at_end;

  assign out_tvalid = valid_r;
  assign char_code  = char_r;
  assign end_of_run = last_r;

  // output register takes a new character whenever a request is waiting and it is free or drained
  assign load   = !empty && (!valid_r || out_tready);
  assign at_end = (idx_r == head.last_idx);
  assign pop    = load && at_end;

  // character index and output valid
  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = at_end ? 2'd0 : idx_r + 2'd1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= head.chars[idx_r];
      last_r <= at_end;
    end
  end

`ifndef SYNTHESIS
  // the character index never runs past the request it walks
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> idx_r <= head.last_idx)
    else $error("character index beyond request");
  // a finished request leaves the index at the first slot
  a_idx_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> idx_r == 2'd0)
    else $error("index not cleared after request");
`endif

endmodule

/* bench/testbench.sv */
// self-checking testbench for the streaming base64 encoder
`timescale 1ns / 1ps
module testbench;
  import b64e_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int ITEM_TARGET  = 410;
  localparam int HOLD_CYCLES  = 120;
  localparam int HOLD_AT_CHAR = 150;
  localparam int DRAIN_CYCLES = 12;

  // one expected character request
  typedef struct packed {
    logic [6:0] code;
    logic       tail;
  } char_exp_t;

  // running encoder state and the characters still owed by the block
  class char_scoreboard;
    string       alphabet;
    phase_t      phase;
    logic [3:0]  leftover;
    char_exp_t   expected_chars[$];
    int          mismatches;

    function new();
      alphabet   = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
      phase      = PH_FIRST;
      leftover   = 4'd0;
      mismatches = 0;
    endfunction

    function logic [6:0] sextet_char(input logic [5:0] s);
      byte c;
      c = alphabet[int'(s)];
      return c[6:0];
    endfunction

    task report_mismatch(input string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      mismatches++;
    endtask

    // work out the characters one accepted byte causes
    function void encode_byte(input logic [7:0] b, input logic last);
      logic [6:0] codes[$];
      char_exp_t  e;
      case (phase)
        PH_SECOND: begin
          codes.push_back(sextet_char({leftover[1:0], b[7:4]}));
          if (last) begin
            codes.push_back(sextet_char({b[3:0], 2'b00}));
            codes.push_back(PAD_CHAR);
          end
          leftover = b[3:0];
          phase    = PH_THIRD;
        end
        PH_THIRD: begin
          codes.push_back(sextet_char({leftover, b[7:6]}));
          codes.push_back(sextet_char(b[5:0]));
          leftover = 4'd0;
          phase    = PH_FIRST;
        end
        default: begin
          codes.push_back(sextet_char(b[7:2]));
          if (last) begin
            codes.push_back(sextet_char({b[1:0], 4'b0000}));
            codes.push_back(PAD_CHAR);
            codes.push_back(PAD_CHAR);
          end
          leftover = {2'b00, b[1:0]};
          phase    = PH_SECOND;
        end
      endcase
      // a last byte closes the group
      if (last) begin
        phase    = PH_FIRST;
        leftover = 4'd0;
      end
      foreach (codes[i]) begin
        e.code = codes[i];
        e.tail = (i == codes.size() - 1);
        expected_chars.push_back(e);
      end
    endfunction

    // compare one accepted character with the oldest expectation
    task check_char(input logic [7:0] data, input logic tlast);
      char_exp_t e;
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char 0x%02h last=%0b", data, tlast));
      end else begin
        e = expected_chars.pop_front();
        if (data !== {1'b0, e.code})
          report_mismatch($sformatf("char 0x%02h, expected 0x%02h", data, e.code));
        if (tlast !== e.tail)
          report_mismatch($sformatf("tlast %0b, expected %0b (char 0x%02h)",
                                    tlast, e.tail, e.code));
      end
    endtask

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic       out_tlast;

  char_scoreboard sb;
  int bytes_sent;
  int chars_seen;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;

  base64_encoder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // cycle counter and run limit
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("** base64_encoder: FAILED **");
    $finish;
  end

  // offer one byte request, with idle cycles first, and wait for acceptance
  task send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom_range(0, 255));
      in_tlast  <= 1'($urandom_range(0, 1));
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    sb.encode_byte(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task send_message(input logic [7:0] msg[$]);
    foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
  endtask

  // idle pattern follows progress through the stimulus
  task pick_idle_mode();
    if (bytes_sent < 140) begin
      send_idle_pct = 28;
      recv_idle_pct = 57;
    end else if (bytes_sent < 280) begin
      send_idle_pct = 57;
      recv_idle_pct = 28;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  // receiver: random stalls plus one long hold-off once traffic is flowing
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 0;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!hold_done && chars_seen >= HOLD_AT_CHAR) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // character monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_char(out_tdata, out_tlast);
      chars_seen++;
    end
  end

  // main stimulus
  initial begin
    logic [7:0] msg[$];
    int len;
    sb         = new();
    bytes_sent = 0;
    chars_seen = 0;
    pick_idle_mode();
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'h00;
    in_tlast  <= 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: single bytes at the extremes, each group position ending a message
    msg = {8'h00};                                  send_message(msg);
    msg = {8'hFF};                                  send_message(msg);
    msg = {8'h00, 8'hFF};                           send_message(msg);
    msg = {8'hFF, 8'h00};                           send_message(msg);
    // '+' characters
    msg = {8'hFB, 8'hEF, 8'hBE};                    send_message(msg);
    msg = {8'h00, 8'h00, 8'h00, 8'h00};             send_message(msg);
    msg = {8'h12, 8'h34, 8'h56, 8'h78, 8'h9A};      send_message(msg);

    // random messages, mostly short, a few long
    while (bytes_sent < ITEM_TARGET) begin
      pick_idle_mode();
      if ($urandom_range(99) < 85) len = $urandom_range(1, 8);
      else len = $urandom_range(9, 30);
      msg.delete();
      repeat (len) msg.push_back(8'($urandom_range(0, 255)));
      send_message(msg);
    end
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;

    // drain, then allow for stray characters
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("** base64_encoder: PASSED **");
    end else begin
      $display("** base64_encoder: FAILED **");
    end
    $finish;
  end

endmodule

/* base64_encoder.f */
design/b64e_pkg.sv
design/b64e_front.sv
design/b64e_fifo.sv
design/b64e_back.sv
design/base64_encoder.sv
bench/testbench.sv
